// ===== hdl/ddl_pkg.sv =====
// Shared types, constants and helper functions for the deadline I/O dispatcher.
`default_nettype none

package ddl_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int MEM_DEPTH   = 2 * QUEUE_DEPTH;
   localparam int HEAD_W      = $clog2(QUEUE_DEPTH);
   localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int ADDR_W      = $clog2(MEM_DEPTH);
   localparam int MAX_RESULTS = 32;
   localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

   localparam int EXPIRY_W   = 20;
   localparam int LIMIT_W    = 5;
   localparam int CSR_DATA_W = 20;
   localparam int CSR_IDX_W  = 2;
   localparam int WAIT_W     = 5;

   localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

   // length / 5 == (length * 52429) >> 18 for any 16-bit length
   localparam logic [15:0] DIV5_MUL   = 16'd52429;
   localparam int          DIV5_SHIFT = 18;

   localparam logic [EXPIRY_W-1:0] RESET_READ_EXPIRY  = EXPIRY_W'(500);
   localparam logic [EXPIRY_W-1:0] RESET_WRITE_EXPIRY = EXPIRY_W'(1000);
   localparam logic [LIMIT_W-1:0]  RESET_READ_LIMIT   = LIMIT_W'(4);
   localparam logic [LIMIT_W-1:0]  RESET_WRITE_LIMIT  = LIMIT_W'(2);

   localparam logic [CSR_IDX_W-1:0] REG_READ_EXPIRY  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_WRITE_EXPIRY = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_READ_LIMIT   = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_WRITE_LIMIT  = CSR_IDX_W'(3);

   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_TICK    = 1'b1;

   localparam logic [1:0] TYPE_READ    = 2'd0;
   localparam logic [1:0] TYPE_WRITE   = 2'd1;
   localparam logic [1:0] TYPE_DISCARD = 2'd2;
   localparam logic [1:0] TYPE_FLUSH   = 2'd3;

   typedef enum logic [2:0] {
      KIND_ACCEPTED   = 3'd0,
      KIND_DROPPED    = 3'd1,
      KIND_IGNORED    = 3'd2,
      KIND_DISPATCHED = 3'd3,
      KIND_EXPIRED    = 3'd4
   } kind_type;

   typedef struct packed {
      logic [EXPIRY_W-1:0] read_expiry;
      logic [EXPIRY_W-1:0] write_expiry;
      logic [LIMIT_W-1:0]  read_limit;
      logic [LIMIT_W-1:0]  write_limit;
   } cfg_type;

   typedef struct packed {
      logic        op;
      logic [1:0]  req_type;
      logic [31:0] tag;
      logic [47:0] sector;
      logic [15:0] length;
   } item_type;

   typedef struct packed {
      logic [31:0] id;
      logic [47:0] sector;
      logic [15:0] length;
      logic [31:0] deadline;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      entry_type         data;
   } mem_wr_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } mem_rd_type;

   typedef struct packed {
      logic              valid;
      kind_type          kind;
      logic              is_write;
      logic [31:0]       id;
      logic [47:0]       sector;
      logic [15:0]       length;
      logic [31:0]       finish;
      logic              last;
      logic [FILL_W-1:0] rfill;
      logic [FILL_W-1:0] wfill;
      logic [31:0]       exp_total;
      logic [31:0]       disp_total;
   } emit_type;

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? SAT32 : s[31:0];
   endfunction

   // queue-relative index (may run up to twice the depth) to memory address
   function automatic logic [ADDR_W-1:0] slot_of(input logic is_w,
                                                 input logic [HEAD_W:0] idx);
      logic [HEAD_W:0] w;
      w = (idx >= (HEAD_W+1)'(QUEUE_DEPTH)) ? idx - (HEAD_W+1)'(QUEUE_DEPTH) : idx;
      return ADDR_W'(w) + (is_w ? ADDR_W'(QUEUE_DEPTH) : ADDR_W'(0));
   endfunction

   function automatic logic [HEAD_W-1:0] head_step(input logic [HEAD_W-1:0] h);
      logic [HEAD_W:0] n;
      n = {1'b0, h} + (HEAD_W+1)'(1);
      return (n == (HEAD_W+1)'(QUEUE_DEPTH)) ? HEAD_W'(0) : n[HEAD_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== hdl/ddl_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module ddl_ram #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/ddl_core.sv =====
// Dispatcher sequencer: queue pointers, time, totals, enqueue and tick pop sequencing.
`default_nettype none

module ddl_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  ddl_pkg::item_type  item,
   input  ddl_pkg::cfg_type   cfg,
   input  logic               out_free,
   input  ddl_pkg::entry_type rd_data,
   output logic               busy,
   output ddl_pkg::emit_type  emit,
   output ddl_pkg::mem_wr_type mem_wr,
   output ddl_pkg::mem_rd_type mem_rd
);

   import ddl_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_ENQ  = 4'b0010,
      ST_CHK  = 4'b0100,
      ST_POP  = 4'b1000
   } state_type;

   state_type           state_ff, state_in;
   item_type            item_ff, item_in;
   logic [HEAD_W-1:0]   rd_head_ff, rd_head_in, wr_head_ff, wr_head_in;
   logic [FILL_W-1:0]   rd_fill_ff, rd_fill_in, wr_fill_ff, wr_fill_in;
   logic [31:0]         now_ff, now_in;
   logic [31:0]         exp_tot_ff, exp_tot_in, disp_tot_ff, disp_tot_in;
   logic                phase_w_ff, phase_w_in;
   logic [LIMIT_W-1:0]  done_ff, done_in;
   logic [NRES_W-1:0]   nres_ff, nres_in;

   // enqueue path
   logic              enq_is_w, enq_valid, enq_full;
   logic [FILL_W-1:0] enq_fill;
   logic [HEAD_W-1:0] enq_head;
   logic [31:0]       enq_deadline;

   // pop path
   logic              pop_w;
   logic [HEAD_W-1:0] pop_head;
   logic              rd_ok, wr_ok, pop_expired, pop_more;
   logic [31:0]       pop_prod, pop_finish;
   logic [15:0]       pop_q5, pop_q;
   logic [FILL_W-1:0] rd_fill_dec, wr_fill_dec;
   logic [LIMIT_W-1:0] done_after;
   logic [NRES_W-1:0] nres_after;
   logic [31:0]       exp_tot_after, disp_tot_after;

   always_comb begin
      enq_is_w     = item_ff.req_type[0];
      enq_valid    = !item_ff.req_type[1];
      enq_fill     = enq_is_w ? wr_fill_ff : rd_fill_ff;
      enq_head     = enq_is_w ? wr_head_ff : rd_head_ff;
      enq_full     = (enq_fill == FILL_W'(QUEUE_DEPTH));
      enq_deadline = sat_add(now_ff, 32'(enq_is_w ? cfg.write_expiry : cfg.read_expiry));
   end

   always_comb begin
      pop_w    = phase_w_ff;
      pop_head = pop_w ? wr_head_ff : rd_head_ff;
      rd_ok    = !phase_w_ff && (done_ff < cfg.read_limit) && (rd_fill_ff != '0)
                 && (nres_ff < NRES_W'(MAX_RESULTS));
      wr_ok    = phase_w_ff && (done_ff < cfg.write_limit) && (wr_fill_ff != '0)
                 && (nres_ff < NRES_W'(MAX_RESULTS));

      pop_expired = (rd_data.deadline < now_ff);
      pop_prod    = 32'(rd_data.length) * 32'(DIV5_MUL);
      pop_q5      = 16'(pop_prod >> DIV5_SHIFT);
      pop_q       = pop_w ? pop_q5 : (pop_q5 >> 1);
      pop_finish  = sat_add(now_ff, 32'(pop_q));

      rd_fill_dec = pop_w ? rd_fill_ff : rd_fill_ff - FILL_W'(1);
      wr_fill_dec = pop_w ? wr_fill_ff - FILL_W'(1) : wr_fill_ff;
      done_after  = pop_expired ? done_ff : done_ff + LIMIT_W'(1);
      nres_after  = nres_ff + NRES_W'(1);
      exp_tot_after  = pop_expired ? sat_add(exp_tot_ff, 32'd1) : exp_tot_ff;
      disp_tot_after = pop_expired ? disp_tot_ff : sat_add(disp_tot_ff, 32'd1);

      if (!pop_w) begin
         pop_more = ((done_after < cfg.read_limit) && (rd_fill_dec != '0)
                     && (nres_after < NRES_W'(MAX_RESULTS)))
                    || ((cfg.write_limit != '0) && (wr_fill_ff != '0)
                        && (nres_after < NRES_W'(MAX_RESULTS)));
      end else begin
         pop_more = (done_after < cfg.write_limit) && (wr_fill_dec != '0)
                    && (nres_after < NRES_W'(MAX_RESULTS));
      end
   end

   always_comb begin
      state_in   = state_ff;
      item_in    = item_ff;
      rd_head_in = rd_head_ff;
      wr_head_in = wr_head_ff;
      rd_fill_in = rd_fill_ff;
      wr_fill_in = wr_fill_ff;
      now_in     = now_ff;
      exp_tot_in = exp_tot_ff;
      disp_tot_in = disp_tot_ff;
      phase_w_in = phase_w_ff;
      done_in    = done_ff;
      nres_in    = nres_ff;
      emit       = '0;
      mem_wr     = '0;
      mem_rd     = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               item_in = item;
               if (item.op == OP_TICK) begin
                  phase_w_in = 1'b0;
                  done_in    = '0;
                  nres_in    = '0;
                  state_in   = ST_CHK;
               end else begin
                  state_in = ST_ENQ;
               end
            end
         end
         ST_ENQ: begin
            if (out_free) begin
               emit.valid  = 1'b1;
               emit.id     = item_ff.tag;
               emit.sector = item_ff.sector;
               emit.length = item_ff.length;
               emit.last   = 1'b1;
               emit.rfill  = rd_fill_ff;
               emit.wfill  = wr_fill_ff;
               emit.exp_total  = exp_tot_ff;
               emit.disp_total = disp_tot_ff;
               if (!enq_valid) begin
                  emit.kind = KIND_IGNORED;
               end else if (enq_full) begin
                  emit.kind     = KIND_DROPPED;
                  emit.is_write = enq_is_w;
               end else begin
                  emit.kind     = KIND_ACCEPTED;
                  emit.is_write = enq_is_w;
                  mem_wr.en     = 1'b1;
                  mem_wr.addr   = slot_of(enq_is_w,
                                          {1'b0, enq_head} + (HEAD_W+1)'(enq_fill));
                  mem_wr.data.id       = item_ff.tag;
                  mem_wr.data.sector   = item_ff.sector;
                  mem_wr.data.length   = item_ff.length;
                  mem_wr.data.deadline = enq_deadline;
                  if (enq_is_w) begin
                     wr_fill_in  = wr_fill_ff + FILL_W'(1);
                     emit.wfill  = wr_fill_ff + FILL_W'(1);
                  end else begin
                     rd_fill_in  = rd_fill_ff + FILL_W'(1);
                     emit.rfill  = rd_fill_ff + FILL_W'(1);
                  end
               end
               state_in = ST_IDLE;
            end
         end
         ST_CHK: begin
            if (rd_ok || wr_ok) begin
               mem_rd.en   = 1'b1;
               mem_rd.addr = slot_of(pop_w, {1'b0, pop_head});
               state_in    = ST_POP;
            end else if (!phase_w_ff) begin
               phase_w_in = 1'b1;
               done_in    = '0;
            end else begin
               now_in   = sat_add(now_ff, 32'd1);
               state_in = ST_IDLE;
            end
         end
         ST_POP: begin
            if (out_free) begin
               emit.valid    = 1'b1;
               emit.kind     = pop_expired ? KIND_EXPIRED : KIND_DISPATCHED;
               emit.is_write = pop_w;
               emit.id       = rd_data.id;
               emit.sector   = rd_data.sector;
               emit.length   = rd_data.length;
               emit.finish   = pop_expired ? 32'd0 : pop_finish;
               emit.last     = !pop_more;
               emit.rfill    = rd_fill_dec;
               emit.wfill    = wr_fill_dec;
               emit.exp_total  = exp_tot_after;
               emit.disp_total = disp_tot_after;
               if (pop_w) begin
                  wr_head_in = head_step(wr_head_ff);
               end else begin
                  rd_head_in = head_step(rd_head_ff);
               end
               rd_fill_in  = rd_fill_dec;
               wr_fill_in  = wr_fill_dec;
               done_in     = done_after;
               nres_in     = nres_after;
               exp_tot_in  = exp_tot_after;
               disp_tot_in = disp_tot_after;
               state_in    = ST_CHK;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         rd_head_ff  <= '0;
         wr_head_ff  <= '0;
         rd_fill_ff  <= '0;
         wr_fill_ff  <= '0;
         now_ff      <= '0;
         exp_tot_ff  <= '0;
         disp_tot_ff <= '0;
         phase_w_ff  <= 1'b0;
         done_ff     <= '0;
         nres_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         rd_head_ff  <= rd_head_in;
         wr_head_ff  <= wr_head_in;
         rd_fill_ff  <= rd_fill_in;
         wr_fill_ff  <= wr_fill_in;
         now_ff      <= now_in;
         exp_tot_ff  <= exp_tot_in;
         disp_tot_ff <= disp_tot_in;
         phase_w_ff  <= phase_w_in;
         done_ff     <= done_in;
         nres_ff     <= nres_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

// ===== hdl/deadline_io_dispatcher.sv =====
// Deadline I/O dispatcher top level: config registers, entry RAM, sequencer, result register.
// Enqueue: the request is latched (ENQ state), then its result is registered once the response
// register is free; the next request is taken after the sequencer returns to idle.
// Tick: per popped entry a RAM read (CHK), then a result (POP), which a stalled response holds;
// a further CHK step switches from the read queue to the write queue and another advances time.
// Reset: synchronous; clears pointers, time, totals and valids, loads default config, keeps RAM.
`default_nettype none

module deadline_io_dispatcher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [1:0]  req_type,
   input  logic [31:0] req_tag,
   input  logic [47:0] req_sector,
   input  logic [15:0] req_length,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic        rsp_is_write,
   output logic [31:0] rsp_out_id,
   output logic [47:0] rsp_out_sector,
   output logic [15:0] rsp_out_length,
   output logic [31:0] rsp_finish_time,
   output logic        rsp_last,
   output logic [4:0]  rsp_reads_waiting,
   output logic [4:0]  rsp_writes_waiting,
   output logic [31:0] rsp_expired_count,
   output logic [31:0] rsp_dispatched_count,
   input  logic        csr_wr_en,
   input  logic [ddl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ddl_pkg::CSR_DATA_W-1:0] csr_wr_data
);

   import ddl_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       rsp_valid_ff, rsp_valid_in;
   emit_type   res_ff, res_in;
   item_type   item;
   emit_type   emit;
   mem_wr_type mem_wr;
   mem_rd_type mem_rd;
   logic [ENTRY_W-1:0] rd_raw;
   entry_type  rd_data;
   logic       accept, busy, out_free;

   assign item.op       = req_op;
   assign item.req_type = req_type;
   assign item.tag      = req_tag;
   assign item.sector   = req_sector;
   assign item.length   = req_length;

   assign req_stall = busy;
   assign accept    = req_valid && !busy;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rd_data   = entry_type'(rd_raw);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_READ_EXPIRY:  cfg_in.read_expiry  = EXPIRY_W'(csr_wr_data);
            REG_WRITE_EXPIRY: cfg_in.write_expiry = EXPIRY_W'(csr_wr_data);
            REG_READ_LIMIT:   cfg_in.read_limit   = LIMIT_W'(csr_wr_data);
            REG_WRITE_LIMIT:  cfg_in.write_limit  = LIMIT_W'(csr_wr_data);
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      res_in       = res_ff;
      if (emit.valid) begin
         rsp_valid_in = 1'b1;
         res_in       = emit;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.read_expiry  <= RESET_READ_EXPIRY;
         cfg_ff.write_expiry <= RESET_WRITE_EXPIRY;
         cfg_ff.read_limit   <= RESET_READ_LIMIT;
         cfg_ff.write_limit  <= RESET_WRITE_LIMIT;
         rsp_valid_ff        <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   ddl_ram #(
      .DEPTH (MEM_DEPTH),
      .WIDTH (ENTRY_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr.en),
      .wr_addr (mem_wr.addr),
      .wr_data (mem_wr.data),
      .rd_en   (mem_rd.en),
      .rd_addr (mem_rd.addr),
      .rd_data (rd_raw)
   );

   ddl_core u_core (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .item     (item),
      .cfg      (cfg_ff),
      .out_free (out_free),
      .rd_data  (rd_data),
      .busy     (busy),
      .emit     (emit),
      .mem_wr   (mem_wr),
      .mem_rd   (mem_rd)
   );

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_kind             = res_ff.kind;
   assign rsp_is_write         = res_ff.is_write;
   assign rsp_out_id           = res_ff.id;
   assign rsp_out_sector       = res_ff.sector;
   assign rsp_out_length       = res_ff.length;
   assign rsp_finish_time      = res_ff.finish;
   assign rsp_last             = res_ff.last;
   assign rsp_reads_waiting    = WAIT_W'(res_ff.rfill);
   assign rsp_writes_waiting   = WAIT_W'(res_ff.wfill);
   assign rsp_expired_count    = res_ff.exp_total;
   assign rsp_dispatched_count = res_ff.disp_total;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("sequencer idle right after accepting a request");

   a_emit_busy: assert property (@(posedge clock) disable iff (reset)
      emit.valid |-> busy)
      else $error("result produced with no request in progress");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      emit.valid |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result overwrote a stalled response");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (res_ff.rfill <= FILL_W'(QUEUE_DEPTH)
                        && res_ff.wfill <= FILL_W'(QUEUE_DEPTH)))
      else $error("queue fill beyond depth");

endmodule

`default_nettype wire
